FILE: design/swfd_pkg.sv
// Shared types and constants for the scale weight frame decoder.
// No dependencies; every other file imports this package.
package swfd_pkg;

  localparam int FRAME_LEN   = 20;
  localparam int STORE_DEPTH = FRAME_LEN - 1;
  localparam int POS_W       = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  localparam logic [7:0] PRODUCT_ID      = 8'h03;
  localparam logic [7:0] TYPE_WEIGHT     = 8'h0B;
  localparam logic [7:0] SIGN_MINUS      = 8'h2D;
  localparam logic [7:0] UNIT_OUNCE_CODE = 8'h01;
  localparam logic [7:0] UNIT_GRAM_CODE  = 8'h02;

  // queue between front and back; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int TIMER_W  = 24;
  localparam int WEIGHT_W = 25;
  localparam int FLOW_W   = 17;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_CSUM_FAIL = 2'd1,
    ST_IGNORED   = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    UNIT_OUNCE   = 2'd0,
    UNIT_GRAM    = 2'd1,
    UNIT_UNKNOWN = 2'd2
  } weight_unit_t;

  // classified frame, raw bytes still undecoded
  typedef struct packed {
    frame_status_t status;
    logic [23:0]   timer;
    logic [7:0]    unit_code;
    logic [7:0]    weight_sign;
    logic [23:0]   weight_mag;
    logic [7:0]    flow_sign;
    logic [15:0]   flow_mag;
    logic [7:0]    battery;
    logic [7:0]    auto_stop;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } q_push_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } q_head_t;

endpackage

FILE: design/swfd_if.sv
// Valid/ready channel interfaces for the decoder's byte input and frame output.
// Depends on swfd_pkg.
interface swfd_in_if;
  import swfd_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface swfd_out_if;
  import swfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 frame_status;
  logic [TIMER_W-1:0]         timer_ms;
  logic [1:0]                 weight_unit;
  logic signed [WEIGHT_W-1:0] weight_hundredths;
  logic signed [FLOW_W-1:0]   flow_hundredths;
  logic [7:0]                 battery_percent;
  logic [7:0]                 auto_stop;

  modport source (
    output valid, output frame_status, output timer_ms, output weight_unit,
    output weight_hundredths, output flow_hundredths, output battery_percent,
    output auto_stop, input ready
  );
  modport sink (
    input valid, input frame_status, input timer_ms, input weight_unit,
    input weight_hundredths, input flow_hundredths, input battery_percent,
    input auto_stop, output ready
  );
endinterface

FILE: design/scale_weight_frame_decoder_top.sv
// A frame's record enters the queue when its twentieth byte transfers, then moves to the output register.
// Throughput: one byte per cycle; a new frame may start the cycle after the last.
// The closing byte of a frame stalls only while the two-entry record queue
// is full; the output register drains it at one record per cycle while out_ready is high or it is empty.
// Reset (rst_n, synchronous, active low) clears position, checksum, queue and
// output valid; the frame byte store is not reset, each byte is written before use.
module scale_weight_frame_decoder_top (
  input logic         clk,
  input logic         rst_n,
  swfd_in_if.sink     in_ch,
  swfd_out_if.source  out_ch
);
  import swfd_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  swfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_data_byte (in_ch.data_byte),
    .in_ready     (in_ch.ready),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  swfd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  swfd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_frame_status      (out_ch.frame_status),
    .out_timer_ms          (out_ch.timer_ms),
    .out_weight_unit       (out_ch.weight_unit),
    .out_weight_hundredths (out_ch.weight_hundredths),
    .out_flow_hundredths   (out_ch.flow_hundredths),
    .out_battery_percent   (out_ch.battery_percent),
    .out_auto_stop         (out_ch.auto_stop)
  );

endmodule

FILE: design/swfd_front.sv
// Front end: collects bytes into a frame, runs the XOR checksum and
// classifies each complete frame into a queue record. Depends on swfd_pkg.
module swfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  output logic                in_ready,
  input  logic                q_full,
  output swfd_pkg::q_push_t   q_push
);
  import swfd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       store_r [STORE_DEPTH];
  logic             last_byte;
  logic             xfer;
  frame_status_t    status;

  assign last_byte = (pos_r == LAST_POS);
  // only the closing byte of a frame needs room in the queue
  assign in_ready  = !last_byte || !q_full;
  assign xfer      = in_valid && in_ready;

  always_comb begin
    if (store_r[0] != PRODUCT_ID || store_r[1] != TYPE_WEIGHT) begin
      status = ST_IGNORED;
    end else if (xor_r != in_data_byte) begin
      status = ST_CSUM_FAIL;
    end else begin
      status = ST_VALID;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    if (xfer) begin
      if (last_byte) begin
        pos_nxt = '0;
        xor_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        xor_nxt = xor_r ^ in_data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && !last_byte) begin
      store_r[pos_r] <= in_data_byte;
    end
  end

  always_comb begin
    q_push.push            = xfer && last_byte;
    q_push.rec.status      = status;
    q_push.rec.timer       = {store_r[2], store_r[3], store_r[4]};
    q_push.rec.unit_code   = store_r[5];
    q_push.rec.weight_sign = store_r[6];
    q_push.rec.weight_mag  = {store_r[7], store_r[8], store_r[9]};
    q_push.rec.flow_sign   = store_r[10];
    q_push.rec.flow_mag    = {store_r[11], store_r[12]};
    q_push.rec.battery     = store_r[13];
    q_push.rec.auto_stop   = store_r[18];
  end

endmodule

FILE: design/swfd_fifo.sv
// Short record queue between front and back ends.
// Depends on swfd_pkg.
module swfd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  swfd_pkg::q_push_t q_push,
  input  logic              q_pop,
  output logic              q_full,
  output swfd_pkg::q_head_t q_head
);
  import swfd_pkg::*;

  frame_rec_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              wr_en, rd_en;

  assign q_full = (cnt_r == QCNT_W'(QDEPTH));
  assign wr_en  = q_push.push && !q_full;
  assign rd_en  = q_pop && (cnt_r != '0);

  assign q_head.valid = (cnt_r != '0);
  assign q_head.rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= q_push.rec;
    end
  end

endmodule

FILE: design/swfd_back.sv
// Back end: decodes a queued frame record into result fields and holds
// them in the output register. Depends on swfd_pkg.
module swfd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swfd_pkg::q_head_t                  q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_frame_status,
  output logic [swfd_pkg::TIMER_W-1:0]       out_timer_ms,
  output logic [1:0]                         out_weight_unit,
  output logic signed [swfd_pkg::WEIGHT_W-1:0] out_weight_hundredths,
  output logic signed [swfd_pkg::FLOW_W-1:0] out_flow_hundredths,
  output logic [7:0]                         out_battery_percent,
  output logic [7:0]                         out_auto_stop
);
  import swfd_pkg::*;

  logic                valid_r;
  logic                take;
  frame_rec_t          rec;
  logic                ok;
  weight_unit_t        unit;
  logic [WEIGHT_W-1:0] weight_ext, weight_val;
  logic [FLOW_W-1:0]   flow_ext, flow_val;

  logic [1:0]          status_r;
  logic [TIMER_W-1:0]  timer_r;
  logic [1:0]          unit_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [FLOW_W-1:0]   flow_r;
  logic [7:0]          battery_r;
  logic [7:0]          auto_stop_r;

  assign take  = !valid_r || out_ready;
  assign q_pop = take && q_head.valid;
  assign rec   = q_head.rec;
  assign ok    = (rec.status == ST_VALID);

  always_comb begin
    case (rec.unit_code)
      UNIT_OUNCE_CODE: unit = UNIT_OUNCE;
      UNIT_GRAM_CODE:  unit = UNIT_GRAM;
      default:         unit = UNIT_UNKNOWN;
    endcase
  end

  always_comb begin
    weight_ext = {1'b0, rec.weight_mag};
    flow_ext   = {1'b0, rec.flow_mag};
    weight_val = (rec.weight_sign == SIGN_MINUS) ? (~weight_ext + 1'b1) : weight_ext;
    flow_val   = (rec.flow_sign == SIGN_MINUS) ? (~flow_ext + 1'b1) : flow_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= q_head.valid;
    end
  end

  // flagged frames carry only their status
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r    <= rec.status;
      timer_r     <= ok ? rec.timer : '0;
      unit_r      <= ok ? unit : 2'b0;
      weight_r    <= ok ? weight_val : '0;
      flow_r      <= ok ? flow_val : '0;
      battery_r   <= ok ? rec.battery : '0;
      auto_stop_r <= ok ? rec.auto_stop : '0;
    end
  end

  assign out_valid             = valid_r;
  assign out_frame_status      = status_r;
  assign out_timer_ms          = timer_r;
  assign out_weight_unit       = unit_r;
  assign out_weight_hundredths = signed'(weight_r);
  assign out_flow_hundredths   = signed'(flow_r);
  assign out_battery_percent   = battery_r;
  assign out_auto_stop         = auto_stop_r;

endmodule
